// ----- sv/gls_pkg.sv -----
package gls_pkg;

    localparam int BUTTON_COUNT = 8;
    localparam int CFG_DATA_W   = 20;
    localparam int CFG_INDEX_W  = 3;

    // link states
    localparam logic [1:0] LINK_IDLE  = 2'd0;
    localparam logic [1:0] LINK_ADV   = 2'd1;
    localparam logic [1:0] LINK_CONN  = 2'd2;
    localparam logic [1:0] LINK_OTHER = 2'd3;

    // button bit positions
    localparam int BIT_SELECT = 2;
    localparam int BIT_START  = 3;
    localparam int BIT_UP     = 4;
    localparam int BIT_DOWN   = 5;
    localparam int BIT_LEFT   = 6;
    localparam int BIT_RIGHT  = 7;

    // hat codes
    localparam logic [3:0] HAT_NONE       = 4'd0;
    localparam logic [3:0] HAT_UP         = 4'd1;
    localparam logic [3:0] HAT_UP_RIGHT   = 4'd2;
    localparam logic [3:0] HAT_RIGHT      = 4'd3;
    localparam logic [3:0] HAT_DOWN_RIGHT = 4'd4;
    localparam logic [3:0] HAT_DOWN       = 4'd5;
    localparam logic [3:0] HAT_DOWN_LEFT  = 4'd6;
    localparam logic [3:0] HAT_LEFT       = 4'd7;
    localparam logic [3:0] HAT_UP_LEFT    = 4'd8;

    localparam logic signed [7:0] AXIS_POS = 8'sd127;
    localparam logic signed [7:0] AXIS_NEG = -8'sd127;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_LINK_IDLE_TIMEOUT    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INACTIVITY_TIMEOUT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ADVERTISE_TIMEOUT    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_POWER_HOLD_TICKS     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RECONNECT_HOLD_TICKS = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_BATTERY_LEVEL    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_BLINK_HALF_PERIOD    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_BATTERY_CHECK_PERIOD = 3'd7;

    typedef struct packed {
        logic [19:0] link_idle_timeout;
        logic [19:0] inactivity_timeout;
        logic [19:0] advertise_timeout;
        logic [19:0] power_hold_ticks;
        logic [19:0] reconnect_hold_ticks;
        logic [6:0]  low_battery_level;
        logic [9:0]  blink_half_period;
        logic [15:0] battery_check_period;
    } t_cfg;

    typedef struct packed {
        logic [BUTTON_COUNT-1:0] buttons;
        logic [1:0]              link_state;
        logic [6:0]              battery_level;
        logic                    charging;
        logic                    charge_done;
    } t_in_item;

    typedef struct packed {
        logic              report_valid;
        logic [3:0]        hat;
        logic signed [7:0] axis_x;
        logic signed [7:0] axis_y;
        logic              sleep_request;
        logic              disconnect_request;
        logic              stop_adv_request;
        logic              start_adv_request;
        logic              battery_notify;
        logic              red_led_on;
        logic              green_led_on;
        logic              blue_led_on;
    } t_out_item;

endpackage

// ----- sv/gls_cfg_regs.sv -----
module gls_cfg_regs
    import gls_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.link_idle_timeout    <= 20'd60000;
            r_cfg.inactivity_timeout   <= 20'd300000;
            r_cfg.advertise_timeout    <= 20'd30000;
            r_cfg.power_hold_ticks     <= 20'd5000;
            r_cfg.reconnect_hold_ticks <= 20'd5000;
            r_cfg.low_battery_level    <= 7'd20;
            r_cfg.blink_half_period    <= 10'd500;
            r_cfg.battery_check_period <= 16'd5000;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_LINK_IDLE_TIMEOUT:    r_cfg.link_idle_timeout    <= i_cfg_data;
                REG_INACTIVITY_TIMEOUT:   r_cfg.inactivity_timeout   <= i_cfg_data;
                REG_ADVERTISE_TIMEOUT:    r_cfg.advertise_timeout    <= i_cfg_data;
                REG_POWER_HOLD_TICKS:     r_cfg.power_hold_ticks     <= i_cfg_data;
                REG_RECONNECT_HOLD_TICKS: r_cfg.reconnect_hold_ticks <= i_cfg_data;
                REG_LOW_BATTERY_LEVEL:    r_cfg.low_battery_level    <= i_cfg_data[6:0];
                REG_BLINK_HALF_PERIOD:    r_cfg.blink_half_period    <= i_cfg_data[9:0];
                REG_BATTERY_CHECK_PERIOD: r_cfg.battery_check_period <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- sv/gls_step.sv -----
module gls_step
    import gls_pkg::*;
#(
    parameter int TIMER_WIDTH = 20
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_advance,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    localparam int TW = TIMER_WIDTH;
    localparam int CW = (TIMER_WIDTH > 20) ? TIMER_WIDTH : 20;
    localparam logic [TW-1:0] TMAX = '1;

    logic [BUTTON_COUNT-1:0] r_prev_buttons, n_prev_buttons;
    logic [1:0]              r_prev_link, n_prev_link;
    logic [TW-1:0]           r_idle, n_idle;
    logic [TW-1:0]           r_activity, n_activity;
    logic [TW-1:0]           r_advertise, n_advertise;
    logic [15:0]             r_battery_el, n_battery_el;
    logic [6:0]              r_prev_battery, n_prev_battery;
    logic                    r_start_holding, n_start_holding;
    logic [TW-1:0]           r_start_ticks, n_start_ticks;
    logic                    r_select_holding, n_select_holding;
    logic [TW-1:0]           r_select_ticks, n_select_ticks;
    logic [10:0]             r_phase, n_phase;

    logic [9:0]  half;
    logic [11:0] phase_inc;
    logic        blink_on;
    logic        conn, adv, idle, changed;
    logic        u, d, l, r;
    logic        batt_past;
    logic        idle_past, act_past, adv_past, start_reached, select_reached;
    t_out_item   res;

    always_comb begin
        half      = (i_cfg.blink_half_period == 10'd0) ? 10'd1 : i_cfg.blink_half_period;
        phase_inc = {1'b0, r_phase} + 12'd1;
        n_phase   = (phase_inc >= {1'b0, half, 1'b0}) ? 11'd0 : phase_inc[10:0];
        blink_on  = n_phase >= {1'b0, half};

        n_idle       = (r_idle == TMAX) ? r_idle : r_idle + 1'b1;
        n_activity   = (r_activity == TMAX) ? r_activity : r_activity + 1'b1;
        n_advertise  = (r_advertise == TMAX) ? r_advertise : r_advertise + 1'b1;
        n_battery_el = (r_battery_el == 16'hFFFF) ? r_battery_el : r_battery_el + 16'd1;
        n_start_ticks = r_start_ticks;
        if (r_start_holding && r_start_ticks != TMAX) n_start_ticks = r_start_ticks + 1'b1;
        n_select_ticks = r_select_ticks;
        if (r_select_holding && r_select_ticks != TMAX) n_select_ticks = r_select_ticks + 1'b1;

        res            = '0;
        n_prev_link    = i_item.link_state;
        n_prev_buttons = i_item.buttons;
        n_prev_battery = r_prev_battery;

        conn = i_item.link_state == LINK_CONN;
        adv  = i_item.link_state == LINK_ADV;
        idle = i_item.link_state == LINK_IDLE;

        // link transitions
        if (i_item.link_state != r_prev_link) begin
            if (idle)      n_idle = '0;
            else if (adv)  n_advertise = '0;
            else if (conn) res.battery_notify = 1'b1;
        end

        // button change: restart inactivity, then report or wake advertising
        u = i_item.buttons[BIT_UP];
        d = i_item.buttons[BIT_DOWN];
        l = i_item.buttons[BIT_LEFT];
        r = i_item.buttons[BIT_RIGHT];
        changed = i_item.buttons != r_prev_buttons;
        if (changed) begin
            n_activity = '0;
            if (conn) begin
                res.report_valid = 1'b1;
                if (u && r)      res.hat = HAT_UP_RIGHT;
                else if (r && d) res.hat = HAT_DOWN_RIGHT;
                else if (d && l) res.hat = HAT_DOWN_LEFT;
                else if (l && u) res.hat = HAT_UP_LEFT;
                else if (u)      res.hat = HAT_UP;
                else if (r)      res.hat = HAT_RIGHT;
                else if (d)      res.hat = HAT_DOWN;
                else if (l)      res.hat = HAT_LEFT;
                else             res.hat = HAT_NONE;
                res.axis_x = r ? AXIS_POS : (l ? AXIS_NEG : 8'sd0);
                res.axis_y = d ? AXIS_POS : (u ? AXIS_NEG : 8'sd0);
            end else if (idle && !r_select_holding) begin
                res.start_adv_request = 1'b1;
            end
        end

        // periodic battery check
        batt_past = (n_battery_el > i_cfg.battery_check_period) || (n_battery_el == 16'hFFFF);
        if (batt_past) begin
            if (i_item.battery_level != r_prev_battery) begin
                n_prev_battery = i_item.battery_level;
                if (conn) res.battery_notify = 1'b1;
            end
            n_battery_el = '0;
        end

        res.red_led_on   = (n_prev_battery < i_cfg.low_battery_level) && blink_on;
        res.green_led_on = i_item.charge_done || (i_item.charging && blink_on);

        idle_past = (CW'(n_idle) > CW'(i_cfg.link_idle_timeout)) || (n_idle == TMAX);
        act_past  = (CW'(n_activity) > CW'(i_cfg.inactivity_timeout)) || (n_activity == TMAX);
        adv_past  = (CW'(n_advertise) > CW'(i_cfg.advertise_timeout)) || (n_advertise == TMAX);
        if (idle && idle_past) res.sleep_request = 1'b1;
        if (act_past)          res.sleep_request = 1'b1;

        res.blue_led_on = conn;
        if (adv) begin
            if (adv_past) res.stop_adv_request = 1'b1;
            else          res.blue_led_on = blink_on;
        end

        // long-press holds
        start_reached = (CW'(n_start_ticks) >= CW'(i_cfg.power_hold_ticks))
                        || (n_start_ticks == TMAX);
        n_start_holding = r_start_holding;
        if (i_item.buttons[BIT_START]) begin
            if (!r_start_holding) begin
                n_start_holding = 1'b1;
                n_start_ticks   = '0;
            end else if (start_reached) begin
                res.sleep_request = 1'b1;
            end
        end else begin
            n_start_holding = 1'b0;
            n_start_ticks   = '0;
        end

        select_reached = (CW'(n_select_ticks) >= CW'(i_cfg.reconnect_hold_ticks))
                         || (n_select_ticks == TMAX);
        n_select_holding = r_select_holding;
        if (i_item.buttons[BIT_SELECT]) begin
            if (!r_select_holding) begin
                n_select_holding = 1'b1;
                n_select_ticks   = '0;
            end else if (select_reached) begin
                n_select_holding = 1'b0;
                n_select_ticks   = '0;
                if (conn) res.disconnect_request = 1'b1;
                else      res.stop_adv_request   = 1'b1;
            end
        end else begin
            n_select_holding = 1'b0;
            n_select_ticks   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_buttons   <= '0;
            r_prev_link      <= LINK_IDLE;
            r_idle           <= '0;
            r_activity       <= '0;
            r_advertise      <= '0;
            r_battery_el     <= '0;
            r_prev_battery   <= '0;
            r_start_holding  <= 1'b0;
            r_start_ticks    <= '0;
            r_select_holding <= 1'b0;
            r_select_ticks   <= '0;
            r_phase          <= '0;
        end else if (i_advance) begin
            r_prev_buttons   <= n_prev_buttons;
            r_prev_link      <= n_prev_link;
            r_idle           <= n_idle;
            r_activity       <= n_activity;
            r_advertise      <= n_advertise;
            r_battery_el     <= n_battery_el;
            r_prev_battery   <= n_prev_battery;
            r_start_holding  <= n_start_holding;
            r_start_ticks    <= n_start_ticks;
            r_select_holding <= n_select_holding;
            r_select_ticks   <= n_select_ticks;
            r_phase          <= n_phase;
        end
    end

    assign o_result = res;

    // after an advance the phase stays below twice the largest half period (2046)
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_advance) |-> (r_phase < 11'd2046))
        else $error("blink phase out of range");

    a_hold_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_select_holding |-> (r_select_ticks == '0))
        else $error("select tick count without hold");

    a_start_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_start_holding |-> (r_start_ticks == '0))
        else $error("start tick count without hold");

endmodule

// ----- sv/gamepad_link_power_supervisor_core.sv -----
// Channel   Direction  Handshake                  Payload
// -------   ---------  -------------------------  ---------------------------
// in        input      i_in_valid / o_in_ready    i_in_item  (t_in_item)
// out       output     o_out_valid / i_out_ready  o_out_item (t_out_item)
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Each item passes an input register, then one step of combinational logic
// into the result register, one item per cycle while the output is not stalled.
// The rate is set by the single update of the state registers per item.
// Reset is synchronous and active low; it clears state and loads the
// register defaults. A stalled output holds the result register, and the
// input register then holds its item until the result register frees up.
module gamepad_link_power_supervisor_core
    import gls_pkg::*;
#(
    parameter int TIMER_WIDTH = 20
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_item               i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_item              o_out_item,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg      cfg;
    t_out_item result;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      advance;

    // the input stage moves on when the result register is empty or drains
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    gls_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    gls_step #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_report_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_item.report_valid) |->
        (r_out_item.hat == HAT_NONE && r_out_item.axis_x == 8'sd0
         && r_out_item.axis_y == 8'sd0))
        else $error("report fields set without report");

    a_disc_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_item.disconnect_request && r_out_item.stop_adv_request))
        else $error("disconnect and stop advertising together");

    a_report_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_item.report_valid && r_out_item.start_adv_request))
        else $error("report and start advertising together");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_item)))
        else $error("input register lost a stalled item");

endmodule

// ----- tb/sv/gamepad_link_power_supervisor_core_tb.sv -----
module gamepad_link_power_supervisor_core_tb;
    import gls_pkg::*;

    // Saturation points of the elapsed counters (TIMER_WIDTH left at 20).
    localparam logic [19:0] TIMER_TOP   = 20'hFFFFF;
    localparam logic [15:0] BATT_TOP    = 16'hFFFF;

    // Mirrors the supervisor tick by tick and checks each result it emits.
    class supervisor_scoreboard;
        t_cfg        regs;
        t_out_item   pending_q[$];
        int unsigned failures;
        int unsigned ticks_noted;
        int unsigned results_checked;

        logic [7:0]  last_buttons;
        logic [1:0]  last_link;
        logic [19:0] idle_ticks;
        logic [19:0] quiet_ticks;
        logic [19:0] adv_ticks;
        logic [15:0] batt_ticks;
        logic [6:0]  batt_kept;
        bit          start_on;
        logic [19:0] start_ticks;
        bit          select_on;
        logic [19:0] select_ticks;
        logic [10:0] blink_pos;

        function new();
            regs.link_idle_timeout    = 20'd60000;
            regs.inactivity_timeout   = 20'd300000;
            regs.advertise_timeout    = 20'd30000;
            regs.power_hold_ticks     = 20'd5000;
            regs.reconnect_hold_ticks = 20'd5000;
            regs.low_battery_level    = 7'd20;
            regs.blink_half_period    = 10'd500;
            regs.battery_check_period = 16'd5000;
            last_buttons = '0;
            last_link    = LINK_IDLE;
            idle_ticks   = '0;
            quiet_ticks  = '0;
            adv_ticks    = '0;
            batt_ticks   = '0;
            batt_kept    = '0;
            start_on     = 1'b0;
            start_ticks  = '0;
            select_on    = 1'b0;
            select_ticks = '0;
            blink_pos    = '0;
            failures     = 0;
            ticks_noted  = 0;
            results_checked = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_LINK_IDLE_TIMEOUT:    regs.link_idle_timeout    = data;
                REG_INACTIVITY_TIMEOUT:   regs.inactivity_timeout   = data;
                REG_ADVERTISE_TIMEOUT:    regs.advertise_timeout    = data;
                REG_POWER_HOLD_TICKS:     regs.power_hold_ticks     = data;
                REG_RECONNECT_HOLD_TICKS: regs.reconnect_hold_ticks = data;
                REG_LOW_BATTERY_LEVEL:    regs.low_battery_level    = data[6:0];
                REG_BLINK_HALF_PERIOD:    regs.blink_half_period    = data[9:0];
                REG_BATTERY_CHECK_PERIOD: regs.battery_check_period = data[15:0];
                default: ;
            endcase
        endfunction

        function logic [19:0] bump(logic [19:0] v);
            return (v == TIMER_TOP) ? v : v + 20'd1;
        endfunction

        // A pinned counter counts as beyond any limit.
        function bit timed_out(logic [19:0] e, logic [19:0] lim);
            return (e > lim) || (e == TIMER_TOP);
        endfunction

        function bit hold_done(logic [19:0] e, logic [19:0] lim);
            return (e >= lim) || (e == TIMER_TOP);
        endfunction

        function t_out_item advance(t_in_item it);
            t_out_item   r;
            logic [11:0] half;
            bit          blink_on, conn, adv, up, dn, lf, rt;
            r = '0;
            half = (regs.blink_half_period == 10'd0) ? 12'd1 : {2'b00, regs.blink_half_period};

            idle_ticks  = bump(idle_ticks);
            quiet_ticks = bump(quiet_ticks);
            adv_ticks   = bump(adv_ticks);
            if (batt_ticks != BATT_TOP) batt_ticks = batt_ticks + 16'd1;
            if (start_on) start_ticks = bump(start_ticks);
            if (select_on) select_ticks = bump(select_ticks);
            blink_pos = blink_pos + 11'd1;
            if ({1'b0, blink_pos} >= (half << 1)) blink_pos = '0;
            blink_on = ({1'b0, blink_pos} >= half);

            conn = (it.link_state == LINK_CONN);
            adv  = (it.link_state == LINK_ADV);
            if (it.link_state != last_link) begin
                if (it.link_state == LINK_IDLE) idle_ticks = '0;
                else if (adv) adv_ticks = '0;
                else if (conn) r.battery_notify = 1'b1;
                last_link = it.link_state;
            end

            if (it.buttons != last_buttons) begin
                quiet_ticks = '0;
                if (conn) begin
                    up = it.buttons[BIT_UP];
                    dn = it.buttons[BIT_DOWN];
                    lf = it.buttons[BIT_LEFT];
                    rt = it.buttons[BIT_RIGHT];
                    r.report_valid = 1'b1;
                    if (up && rt) r.hat = HAT_UP_RIGHT;
                    else if (rt && dn) r.hat = HAT_DOWN_RIGHT;
                    else if (dn && lf) r.hat = HAT_DOWN_LEFT;
                    else if (lf && up) r.hat = HAT_UP_LEFT;
                    else if (up) r.hat = HAT_UP;
                    else if (rt) r.hat = HAT_RIGHT;
                    else if (dn) r.hat = HAT_DOWN;
                    else if (lf) r.hat = HAT_LEFT;
                    else r.hat = HAT_NONE;
                    r.axis_x = rt ? AXIS_POS : (lf ? AXIS_NEG : 8'sd0);
                    r.axis_y = dn ? AXIS_POS : (up ? AXIS_NEG : 8'sd0);
                end else if (it.link_state == LINK_IDLE && !select_on) begin
                    r.start_adv_request = 1'b1;
                end
            end
            last_buttons = it.buttons;

            if (batt_ticks > regs.battery_check_period || batt_ticks == BATT_TOP) begin
                if (it.battery_level != batt_kept) begin
                    batt_kept = it.battery_level;
                    if (conn) r.battery_notify = 1'b1;
                end
                batt_ticks = '0;
            end

            r.red_led_on   = (batt_kept < regs.low_battery_level) ? blink_on : 1'b0;
            r.green_led_on = it.charge_done ? 1'b1 : (it.charging ? blink_on : 1'b0);

            if (it.link_state == LINK_IDLE && timed_out(idle_ticks, regs.link_idle_timeout))
                r.sleep_request = 1'b1;
            if (timed_out(quiet_ticks, regs.inactivity_timeout))
                r.sleep_request = 1'b1;

            r.blue_led_on = conn;
            if (adv) begin
                if (timed_out(adv_ticks, regs.advertise_timeout)) begin
                    r.stop_adv_request = 1'b1;
                    r.blue_led_on      = 1'b0;
                end else begin
                    r.blue_led_on = blink_on;
                end
            end

            if (it.buttons[BIT_START]) begin
                if (!start_on) begin
                    start_on    = 1'b1;
                    start_ticks = '0;
                end else if (hold_done(start_ticks, regs.power_hold_ticks)) begin
                    r.sleep_request = 1'b1;
                end
            end else begin
                start_on    = 1'b0;
                start_ticks = '0;
            end

            // A completed select hold rearms itself.
            if (it.buttons[BIT_SELECT]) begin
                if (!select_on) begin
                    select_on    = 1'b1;
                    select_ticks = '0;
                end else if (hold_done(select_ticks, regs.reconnect_hold_ticks)) begin
                    select_on    = 1'b0;
                    select_ticks = '0;
                    if (conn) r.disconnect_request = 1'b1;
                    else r.stop_adv_request = 1'b1;
                end
            end else begin
                select_on    = 1'b0;
                select_ticks = '0;
            end
            return r;
        endfunction

        function void note_tick(t_in_item it);
            ticks_noted++;
            pending_q.push_back(advance(it));
        endfunction

        function void diff(string field, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                failures++;
                $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_q.size() == 0) begin
                failures++;
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                return;
            end
            want = pending_q.pop_front();
            results_checked++;
            diff("report_valid", want.report_valid, got.report_valid);
            diff("hat", want.hat, got.hat);
            diff("axis_x", want.axis_x, got.axis_x);
            diff("axis_y", want.axis_y, got.axis_y);
            diff("sleep_request", want.sleep_request, got.sleep_request);
            diff("disconnect_request", want.disconnect_request, got.disconnect_request);
            diff("stop_adv_request", want.stop_adv_request, got.stop_adv_request);
            diff("start_adv_request", want.start_adv_request, got.start_adv_request);
            diff("battery_notify", want.battery_notify, got.battery_notify);
            diff("red_led_on", want.red_led_on, got.red_led_on);
            diff("green_led_on", want.green_led_on, got.green_led_on);
            diff("blue_led_on", want.blue_led_on, got.blue_led_on);
        endfunction

        function int outstanding();
            return pending_q.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    t_in_item               i_in_item;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    t_out_item              o_out_item;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    supervisor_scoreboard sb;

    // Stimulus shaping: current held input, how often buttons and link move,
    // and whether the sender inserts gaps right now.
    t_in_item held_tick;
    int       btn_rate;
    int       link_rate;
    bit       gaps_on;
    int       settings_used;

    // Receiver side: stall countdown and a mode with no stalls at all.
    int       stall_left = 0;
    bit       steady_ready = 1'b0;

    gamepad_link_power_supervisor_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // All three handshakes are observed here, at the rising edge, so the
    // predictor sees ticks and register writes in the order the block does.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) sb.note_tick(i_in_item);
            if (o_out_valid && i_out_ready) sb.check_result(o_out_item);
        end
    end

    // Result side back-pressure: mostly ready, short stalls, now and then a
    // long one, and stretches where it never stalls.
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) steady_ready = ~steady_ready;
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (!steady_ready && $urandom_range(0, 99) < 12) begin
            stall_left = ($urandom_range(0, 99) < 15) ? $urandom_range(5, 20) : $urandom_range(0, 2);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function t_in_item make_tick(logic [7:0] btn, logic [1:0] link, logic [6:0] lvl,
                                 logic chg, logic done);
        t_in_item t;
        t.buttons       = btn;
        t.link_state    = link;
        t.battery_level = lvl;
        t.charging      = chg;
        t.charge_done   = done;
        return t;
    endfunction

    // Mostly a slowly evolving held input (so holds and timeouts complete),
    // with a few fully random ticks mixed in.
    function t_in_item next_tick(bit soak);
        logic [31:0] raw;
        t_in_item    noise;
        int          k;
        if ($urandom_range(0, 49) == 0) begin
            if (soak) begin
                btn_rate  = $urandom_range(0, 1);
                link_rate = 0;
            end else begin
                case ($urandom_range(0, 3))
                    0: btn_rate = 0;
                    1: btn_rate = 2;
                    2: btn_rate = 10;
                    default: btn_rate = 30;
                endcase
                case ($urandom_range(0, 2))
                    0: link_rate = 0;
                    1: link_rate = 1;
                    default: link_rate = 5;
                endcase
            end
        end
        if (!soak && $urandom_range(0, 99) < 4) begin
            raw   = $urandom;
            noise = raw[$bits(t_in_item)-1:0];
            return noise;
        end
        if ($urandom_range(0, 99) < link_rate) held_tick.link_state = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < btn_rate) begin
            case ($urandom_range(0, 4))
                0: begin
                    k = $urandom_range(0, BUTTON_COUNT - 1);
                    held_tick.buttons[k] = ~held_tick.buttons[k];
                end
                1: held_tick.buttons[BIT_SELECT] = ~held_tick.buttons[BIT_SELECT];
                2: held_tick.buttons[BIT_START] = ~held_tick.buttons[BIT_START];
                3: held_tick.buttons[7:4] = 4'($urandom_range(0, 15));
                default: held_tick.buttons = 8'($urandom_range(0, 255));
            endcase
        end
        if ($urandom_range(0, 9) == 0) held_tick.battery_level = 7'($urandom_range(0, 100));
        if ($urandom_range(0, 19) == 0)
            {held_tick.charging, held_tick.charge_done} = 2'($urandom_range(0, 3));
        return held_tick;
    endfunction

    // Presents one tick; valid stays up until the block takes it.
    task automatic send_tick(t_in_item it);
        int g;
        g = gap_len();
        @(negedge i_clk);
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic stop_ticks();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Registers change only with nothing in flight.
    task automatic drain();
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_regs(t_cfg c);
        drain();
        cfg_write(REG_LINK_IDLE_TIMEOUT, c.link_idle_timeout);
        cfg_write(REG_INACTIVITY_TIMEOUT, c.inactivity_timeout);
        cfg_write(REG_ADVERTISE_TIMEOUT, c.advertise_timeout);
        cfg_write(REG_POWER_HOLD_TICKS, c.power_hold_ticks);
        cfg_write(REG_RECONNECT_HOLD_TICKS, c.reconnect_hold_ticks);
        cfg_write(REG_LOW_BATTERY_LEVEL, CFG_DATA_W'(c.low_battery_level));
        cfg_write(REG_BLINK_HALF_PERIOD, CFG_DATA_W'(c.blink_half_period));
        cfg_write(REG_BATTERY_CHECK_PERIOD, CFG_DATA_W'(c.battery_check_period));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic run_random(int n, bit soak);
        repeat (n) begin
            if (soak) gaps_on = 1'b0;
            else if ($urandom_range(0, 49) == 0) gaps_on = ~gaps_on;
            send_tick(next_tick(soak));
        end
        stop_ticks();
    endtask

    function t_cfg short_cfg();
        t_cfg c;
        c.link_idle_timeout    = 20'($urandom_range(1, 60));
        c.inactivity_timeout   = 20'($urandom_range(1, 80));
        c.advertise_timeout    = 20'($urandom_range(1, 60));
        c.power_hold_ticks     = 20'($urandom_range(1, 30));
        c.reconnect_hold_ticks = 20'($urandom_range(1, 30));
        c.low_battery_level    = 7'($urandom_range(0, 127));
        c.blink_half_period    = 10'($urandom_range(1, 12));
        c.battery_check_period = 16'($urandom_range(1, 20));
        return c;
    endfunction

    initial begin
        t_cfg c;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_item    = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        gaps_on      = 1'b1;
        btn_rate     = 10;
        link_rate    = 5;
        settings_used = 1;
        held_tick    = make_tick(8'h00, LINK_IDLE, 7'd60, 1'b0, 1'b0);
        sb = new();

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed ticks at the reset defaults: every hat direction and the
        // conflicting pairs, all-pressed and none, each link state, battery
        // and charger extremes, start advertising with select pressed on the
        // same tick and while it is already held, and a link coming up.
        send_tick(make_tick(8'h10, LINK_CONN, 7'd100, 1'b1, 1'b0));
        send_tick(make_tick(8'h90, LINK_CONN, 7'd0, 1'b0, 1'b1));
        send_tick(make_tick(8'h80, LINK_CONN, 7'd127, 1'b1, 1'b1));
        send_tick(make_tick(8'hA0, LINK_CONN, 7'd50, 1'b0, 1'b0));
        send_tick(make_tick(8'h20, LINK_CONN, 7'd50, 1'b1, 1'b0));
        send_tick(make_tick(8'h60, LINK_CONN, 7'd50, 1'b0, 1'b0));
        send_tick(make_tick(8'h40, LINK_CONN, 7'd50, 1'b0, 1'b0));
        send_tick(make_tick(8'h50, LINK_CONN, 7'd50, 1'b0, 1'b0));
        send_tick(make_tick(8'h30, LINK_CONN, 7'd50, 1'b0, 1'b0));
        send_tick(make_tick(8'hC0, LINK_CONN, 7'd50, 1'b0, 1'b0));
        send_tick(make_tick(8'hFF, LINK_CONN, 7'd50, 1'b0, 1'b0));
        send_tick(make_tick(8'hFF, LINK_CONN, 7'd50, 1'b0, 1'b0));
        send_tick(make_tick(8'h00, LINK_CONN, 7'd50, 1'b0, 1'b0));
        send_tick(make_tick(8'h03, LINK_CONN, 7'd50, 1'b0, 1'b0));
        send_tick(make_tick(8'h01, LINK_IDLE, 7'd50, 1'b0, 1'b0));
        send_tick(make_tick(8'h04, LINK_IDLE, 7'd50, 1'b0, 1'b0));
        send_tick(make_tick(8'h05, LINK_IDLE, 7'd50, 1'b0, 1'b0));
        send_tick(make_tick(8'h00, LINK_ADV, 7'd50, 1'b0, 1'b0));
        send_tick(make_tick(8'h08, LINK_ADV, 7'd50, 1'b0, 1'b0));
        send_tick(make_tick(8'h80, LINK_OTHER, 7'd50, 1'b0, 1'b0));
        send_tick(make_tick(8'h80, LINK_OTHER, 7'd50, 1'b0, 1'b0));
        send_tick(make_tick(8'h80, LINK_CONN, 7'd50, 1'b0, 1'b0));
        stop_ticks();

        // Short timers so that timeouts, holds and checks fire often.
        c.link_idle_timeout    = 20'd20;
        c.inactivity_timeout   = 20'd45;
        c.advertise_timeout    = 20'd30;
        c.power_hold_ticks     = 20'd12;
        c.reconnect_hold_ticks = 20'd8;
        c.low_battery_level    = 7'd50;
        c.blink_half_period    = 10'd3;
        c.battery_check_period = 16'd6;
        program_regs(c);
        run_random(350, 1'b0);

        // Lowest legal settings.
        c.link_idle_timeout    = 20'd1;
        c.inactivity_timeout   = 20'd1;
        c.advertise_timeout    = 20'd1;
        c.power_hold_ticks     = 20'd1;
        c.reconnect_hold_ticks = 20'd1;
        c.low_battery_level    = 7'd0;
        c.blink_half_period    = 10'd1;
        c.battery_check_period = 16'd1;
        program_regs(c);
        run_random(150, 1'b0);

        // All zero: a zero half period behaves as one, zero limits expire
        // at once; the level threshold sits at the top of its field.
        c.link_idle_timeout    = 20'd0;
        c.inactivity_timeout   = 20'd0;
        c.advertise_timeout    = 20'd0;
        c.power_hold_ticks     = 20'd0;
        c.reconnect_hold_ticks = 20'd0;
        c.low_battery_level    = 7'd127;
        c.blink_half_period    = 10'd0;
        c.battery_check_period = 16'd0;
        program_regs(c);
        run_random(120, 1'b0);

        // Highest settings over a quiet stretch: no timer gets near its
        // limit, and the blink phase climbs well past any small period.
        c.link_idle_timeout    = TIMER_TOP;
        c.inactivity_timeout   = TIMER_TOP;
        c.advertise_timeout    = TIMER_TOP;
        c.power_hold_ticks     = TIMER_TOP;
        c.reconnect_hold_ticks = TIMER_TOP;
        c.low_battery_level    = 7'd100;
        c.blink_half_period    = 10'd1023;
        c.battery_check_period = BATT_TOP;
        program_regs(c);
        run_random(250, 1'b1);

        // Blink phase is likely far past a tiny period now and must wrap.
        c = short_cfg();
        c.blink_half_period = 10'd2;
        program_regs(c);
        run_random(500, 1'b0);

        c = short_cfg();
        program_regs(c);
        run_random(250, 1'b0);

        drain();
        repeat (4) @(posedge i_clk);

        $display("covered %0d ticks under %0d register settings, %0d results compared",
                 sb.ticks_noted, settings_used, sb.results_checked);
        $display("%0d mismatches", sb.failures);
        if (sb.failures == 0 && sb.outstanding() == 0) begin
            $display("gamepad_link_power_supervisor_core regression: pass");
        end else begin
            $display("gamepad_link_power_supervisor_core regression: fail");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #300_000_000;
        $display("timeout with %0d results outstanding", sb.outstanding());
        $display("gamepad_link_power_supervisor_core regression: fail");
        $finish;
    end

endmodule
